FILE: hdl/pft_pkg.sv
package pft_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ADDR_W    = 4;
  localparam int PDATA_W   = 32;
  localparam int DIV_STEPS = DATA_W;
  localparam int FRONT_STAGES = 5;
  // front stages + one register per quotient bit + output register
  localparam int PIPE_LAT  = FRONT_STAGES + DIV_STEPS + 1;

  localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] S_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_PRODUCT     = 2'd0,
    OP_ABS_DIFF    = 2'd1,
    OP_SUM         = 2'd2,
    OP_SIGNED_DIFF = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_OPERATION = 2'd0,
    REG_REFERENCE = 2'd1,
    REG_MEAN      = 2'd2,
    REG_SCALE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] reference;
    logic [DATA_W-1:0] mean;
    logic              div_neg;
    logic [DATA_W-1:0] div_mag;
  } cfg_t;

  // one step of the quotient pipeline: partial remainder, and the
  // dividend bits still to shift in sharing a register with the quotient
  typedef struct packed {
    logic              used_ref;
    logic              neg;
    logic              ovf;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] nq;
  } div_stage_t;

endpackage

FILE: hdl/pair_feature_transform_top.sv
// Pipeline: start passes through 5 front stages, 32 quotient stages of one bit each and an
// output register before done rises with the result.
// Throughput: one item per clock; busy is high only during reset.
// done marks each result for a single cycle; there is no output stall.
// Synchronous reset clears the pipeline valid bits and loads register defaults.
module pair_feature_transform_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [pft_pkg::DATA_W-1:0] left_value,
  input  logic signed [pft_pkg::DATA_W-1:0] right_value,
  input  logic                              left_valid,
  input  logic                              right_valid,
  output logic                              done,
  output logic signed [pft_pkg::DATA_W-1:0] feature_value,
  output logic                              used_reference,
  output logic                              saturated,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pft_pkg::ADDR_W-1:0]        paddr,
  input  logic [pft_pkg::PDATA_W-1:0]       pwdata,
  output logic [pft_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  pft_pkg::cfg_t       cfg;
  pft_pkg::div_stage_t front_stage;
  logic                front_valid;
  logic [pft_pkg::DATA_W-1:0] fv;

  assign busy = rst;

  pft_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pft_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (start && !busy),
    .left_value  (left_value),
    .right_value (right_value),
    .left_valid  (left_valid),
    .right_valid (right_valid),
    .out_valid   (front_valid),
    .out_stage   (front_stage)
  );

  pft_div u_div (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (front_valid),
    .in_stage       (front_stage),
    .done           (done),
    .feature_value  (fv),
    .used_reference (used_reference),
    .saturated      (saturated)
  );

  assign feature_value = $signed(fv);

endmodule

FILE: hdl/pft_cfg.sv
module pft_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pft_pkg::ADDR_W-1:0]   paddr,
  input  logic [pft_pkg::PDATA_W-1:0]  pwdata,
  output logic [pft_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output pft_pkg::cfg_t                cfg
);

  pft_pkg::op_t                    operation;
  logic [pft_pkg::DATA_W-1:0]      reference_value;
  logic [pft_pkg::DATA_W-1:0]      mean_value;
  logic [pft_pkg::DATA_W-1:0]      scale_value;
  logic [pft_pkg::DATA_W-1:0]      div_mag;
  logic                            div_neg;
  pft_pkg::reg_idx_t               idx;
  logic                            wr;

  assign pready = 1'b1;
  assign idx    = pft_pkg::reg_idx_t'(paddr[pft_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation       <= pft_pkg::OP_PRODUCT;
      reference_value <= '0;
      mean_value      <= '0;
      scale_value     <= pft_pkg::FIX_ONE;
    end else if (wr) begin
      case (idx)
        pft_pkg::REG_OPERATION: operation       <= pft_pkg::op_t'(pwdata[1:0]);
        pft_pkg::REG_REFERENCE: reference_value <= pwdata[pft_pkg::DATA_W-1:0];
        pft_pkg::REG_MEAN:      mean_value      <= pwdata[pft_pkg::DATA_W-1:0];
        pft_pkg::REG_SCALE:     scale_value     <= pwdata[pft_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // divisor magnitude and sign, zero scale taken as 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      div_mag <= pft_pkg::FIX_ONE;
      div_neg <= 1'b0;
    end else if (scale_value == '0) begin
      div_mag <= pft_pkg::FIX_ONE;
      div_neg <= 1'b0;
    end else begin
      div_mag <= scale_value[pft_pkg::DATA_W-1] ? (~scale_value + pft_pkg::DATA_W'(1))
                                                : scale_value;
      div_neg <= scale_value[pft_pkg::DATA_W-1];
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      pft_pkg::REG_OPERATION: prdata = pft_pkg::PDATA_W'(operation);
      pft_pkg::REG_REFERENCE: prdata = pft_pkg::PDATA_W'(reference_value);
      pft_pkg::REG_MEAN:      prdata = pft_pkg::PDATA_W'(mean_value);
      pft_pkg::REG_SCALE:     prdata = pft_pkg::PDATA_W'(scale_value);
      default:                prdata = '0;
    endcase
  end

  assign cfg.op        = operation;
  assign cfg.reference = reference_value;
  assign cfg.mean      = mean_value;
  assign cfg.div_neg   = div_neg;
  assign cfg.div_mag   = div_mag;

endmodule

FILE: hdl/pft_front.sv
module pft_front (
  input  logic                              clk,
  input  logic                              rst,
  input  pft_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  input  logic signed [pft_pkg::DATA_W-1:0] left_value,
  input  logic signed [pft_pkg::DATA_W-1:0] right_value,
  input  logic                              left_valid,
  input  logic                              right_valid,
  output logic                              out_valid,
  output pft_pkg::div_stage_t               out_stage
);

  localparam int W = pft_pkg::DATA_W;
  localparam int F = pft_pkg::FRAC_BITS;

  // stage 1: multiply, add, subtract
  logic                       s1_valid;
  logic                       s1_ok;
  logic [pft_pkg::PROD_W-1:0] s1_prod;
  logic [W:0]                 s1_sum;
  logic [W:0]                 s1_dif;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_ok   <= left_valid && right_valid;
    s1_prod <= left_value * right_value;
    s1_sum  <= {left_value[W-1], left_value} + {right_value[W-1], right_value};
    s1_dif  <= {left_value[W-1], left_value} - {right_value[W-1], right_value};
  end

  // stage 2: pick raw value, range check, fall back to reference
  logic signed [pft_pkg::PROD_W-1:0] prod_shift;
  logic                              prod_fit;
  logic [W:0]                        abs_dif;
  logic [W-1:0]                      cand;
  logic                              cand_fit;
  logic                              s2_valid;
  logic                              s2_used_ref;
  logic [W-1:0]                      s2_raw;

  assign prod_shift = $signed(s1_prod) >>> F;
  assign prod_fit   = (&prod_shift[pft_pkg::PROD_W-1:W-1]) || !(|prod_shift[pft_pkg::PROD_W-1:W-1]);
  assign abs_dif    = s1_dif[W] ? (~s1_dif + (W+1)'(1)) : s1_dif;

  always_comb begin
    cand     = s1_dif[W-1:0];
    cand_fit = (s1_dif[W] == s1_dif[W-1]);
    case (cfg.op)
      pft_pkg::OP_PRODUCT: begin
        cand     = prod_shift[W-1:0];
        cand_fit = prod_fit;
      end
      pft_pkg::OP_ABS_DIFF: begin
        cand     = abs_dif[W-1:0];
        cand_fit = (abs_dif[W:W-1] == 2'b00);
      end
      pft_pkg::OP_SUM: begin
        cand     = s1_sum[W-1:0];
        cand_fit = (s1_sum[W] == s1_sum[W-1]);
      end
      pft_pkg::OP_SIGNED_DIFF: begin
        cand     = s1_dif[W-1:0];
        cand_fit = (s1_dif[W] == s1_dif[W-1]);
      end
      default: begin
        cand     = s1_dif[W-1:0];
        cand_fit = (s1_dif[W] == s1_dif[W-1]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_used_ref <= !(s1_ok && cand_fit);
    s2_raw      <= (s1_ok && cand_fit) ? cand : cfg.reference;
  end

  // stage 3: subtract mean
  logic       s3_valid;
  logic       s3_used_ref;
  logic [W:0] s3_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_used_ref <= s2_used_ref;
    s3_diff     <= {s2_raw[W-1], s2_raw} - {cfg.mean[W-1], cfg.mean};
  end

  // stage 4: magnitude of the numerator and sign of the quotient
  logic         s4_valid;
  logic         s4_used_ref;
  logic         s4_neg;
  logic [W:0]   diff_abs;
  logic [W-1:0] s4_mag;

  assign diff_abs = s3_diff[W] ? (~s3_diff + (W+1)'(1)) : s3_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_used_ref <= s3_used_ref;
    s4_neg      <= s3_diff[W] ^ cfg.div_neg;
    s4_mag      <= diff_abs[W-1:0];
  end

  // stage 5: scaled numerator split; upper part >= divisor means |q| >= 2^W
  logic [W-1:0] num_hi;

  assign num_hi = W'(s4_mag[W-1:W-F]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s4_valid;
    end
    out_stage.used_ref <= s4_used_ref;
    out_stage.neg      <= s4_neg;
    out_stage.ovf      <= (num_hi >= cfg.div_mag);
    out_stage.rem      <= num_hi;
    out_stage.nq       <= {s4_mag[W-1-F:0], {F{1'b0}}};
  end

endmodule

FILE: hdl/pft_div.sv
module pft_div (
  input  logic                        clk,
  input  logic                        rst,
  input  pft_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  pft_pkg::div_stage_t         in_stage,
  output logic                        done,
  output logic [pft_pkg::DATA_W-1:0]  feature_value,
  output logic                        used_reference,
  output logic                        saturated
);

  localparam int W = pft_pkg::DATA_W;
  localparam int N = pft_pkg::DIV_STEPS;

  logic                vld [N+1];
  pft_pkg::div_stage_t st  [N+1];

  assign vld[0] = in_valid;
  assign st[0]  = in_stage;

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [W:0] r2;
    logic       take;

    assign r2   = {st[i].rem, st[i].nq[W-1]};
    assign take = (r2 >= {1'b0, cfg.div_mag});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      st[i+1].used_ref <= st[i].used_ref;
      st[i+1].neg      <= st[i].neg;
      st[i+1].ovf      <= st[i].ovf;
      st[i+1].rem      <= take ? W'(r2 - {1'b0, cfg.div_mag}) : r2[W-1:0];
      st[i+1].nq       <= {st[i].nq[W-2:0], take};
    end
  end

  // apply sign, clip to range
  logic [W-1:0] qmag;
  logic [W-1:0] q_val;
  logic         q_sat;

  assign qmag = st[N].nq;

  always_comb begin
    q_sat = 1'b0;
    q_val = qmag;
    if (st[N].neg) begin
      if (st[N].ovf || (qmag[W-1] && |qmag[W-2:0])) begin
        q_sat = 1'b1;
        q_val = pft_pkg::S_MIN;
      end else begin
        q_val = ~qmag + W'(1);
      end
    end else if (st[N].ovf || qmag[W-1]) begin
      q_sat = 1'b1;
      q_val = pft_pkg::S_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[N];
    end
    feature_value  <= q_val;
    used_reference <= st[N].used_ref;
    saturated      <= q_sat;
  end

endmodule

FILE: hdl/pft_checker.sv
module pft_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [pft_pkg::DATA_W-1:0]  feature_value,
  input logic                        saturated
);

  // every result traces back to a matching accepted transfer
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, pft_pkg::PIPE_LAT))
    else $error("result strobe without a matching accepted item");

  // every accepted item produces a result
  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(pft_pkg::PIPE_LAT) done)
    else $error("accepted item produced no result");

  // a clipped result sits on one of the range bounds
  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (feature_value == pft_pkg::S_MAX) || (feature_value == pft_pkg::S_MIN))
    else $error("saturated result not at a range bound");

  // no results come out in the cycle right after reset releases
  a_quiet_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

bind pair_feature_transform_top pft_checker u_pft_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .feature_value (feature_value),
  .saturated     (saturated)
);
